// ----- rtl/pfb_pkg.sv -----
package pfb_pkg;

  // Command modes
  localparam logic [1:0] MODE_HLINE = 2'd0;
  localparam logic [1:0] MODE_VLINE = 2'd1;
  localparam logic [1:0] MODE_RECT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_OFFSCR  = 2'd2;

  // Rectangle edges, in drawing order
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_LEFT   = 2'd2;
  localparam logic [1:0] EDGE_RIGHT  = 2'd3;

  localparam int unsigned CHUNK_BYTES = 8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] length;
    logic [7:0] height;
  } in_t;

  typedef struct packed {
    logic [2:0]  page;
    logic [6:0]  column;
    logic [3:0]  byte_count;
    logic [63:0] pixel_bytes;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // One line segment to be checked
  typedef struct packed {
    logic       bad;     // rejected before any geometry check
    logic       vert;
    logic [8:0] col;
    logic [9:0] row;
    logic [7:0] len;
  } seg_t;

  // Check verdict for one segment
  typedef struct packed {
    logic [1:0] status;
    logic       empty;
    logic [9:0] end_row;
  } chk_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEG,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/pfb_ram.sv -----
module pfb_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pfb_check.sv -----
module pfb_check #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  pfb_pkg::seg_t seg,
  output pfb_pkg::chk_t chk
);

  localparam int ROWS = 8 * PAGES;

  logic [10:0] col_w;
  logic [10:0] row_w;
  logic [10:0] len_w;
  logic        invalid;
  logic        offscr;

  assign col_w = {2'b00, seg.col};
  assign row_w = {1'b0, seg.row};
  assign len_w = {3'b000, seg.len};

  always_comb begin
    invalid = seg.bad || (row_w >= 11'(ROWS)) || (col_w >= 11'(COLUMNS)) ||
              (len_w > 11'(COLUMNS));
    if (seg.vert) begin
      offscr = (row_w + len_w) > 11'(ROWS);
    end else begin
      offscr = (col_w + len_w) > 11'(COLUMNS);
    end

    if (invalid) begin
      chk.status = pfb_pkg::STAT_INVALID;
    end else if (offscr) begin
      chk.status = pfb_pkg::STAT_OFFSCR;
    end else begin
      chk.status = pfb_pkg::STAT_OK;
    end
    chk.empty   = (seg.len == 8'd0);
    chk.end_row = seg.row + {2'b00, seg.len} - 10'd1;
  end

endmodule

// ----- rtl/page_framebuffer_line_rect_draw.sv -----
// Channel | Ports                          | Transfer when
// --------+--------------------------------+---------------------------
// input   | in_valid, in_ready, in_data    | in_valid && in_ready
// result  | out_valid, out_ready, out_data | out_valid && out_ready
//
// After reset the framebuffer is swept to zero, one byte a cycle, over all
// COLUMNS*PAGES bytes (1024 by default) with in_ready low. One command at a time.
// A horizontal line is walked in chunks of up to 8 bytes, a vertical line one
// byte per page: one frame RAM read a cycle, then a write-back and an output
// step per chunk. A rejected or empty line gives a single status result; a
// rectangle is walked edge by edge, each edge checked and then walked in chunks.
// A stalled result register holds the sequencer in its output step.
module page_framebuffer_line_rect_draw #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pfb_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pfb_pkg::out_t  out_data
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  // Sequencer state
  pfb_pkg::state_t state_r, state_nxt;
  pfb_pkg::in_t    cmd_r, cmd_nxt;
  logic [1:0]      seg_r, seg_nxt;
  logic            vert_r, vert_nxt;
  logic [PW-1:0]   page_r, page_nxt;
  logic [PW-1:0]   ep_r, ep_nxt;
  logic [2:0]      lo_r, lo_nxt;
  logic [2:0]      hi_r, hi_nxt;
  logic            first_r, first_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [CW-1:0]   ccol_r, ccol_nxt;     // first column of the current chunk
  logic [CW:0]     rem_r, rem_nxt;
  logic [3:0]      iss_r, iss_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            segdone_r, segdone_nxt;
  logic            err_r, err_nxt;       // pending result is status-only
  logic [1:0]      stat_r, stat_nxt;
  logic [63:0]     buf_r, buf_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;

  // Read-merge-write pipe
  logic            pipe_v_r, pipe_v_nxt;
  logic [2:0]      pipe_k_r, pipe_k_nxt;
  logic [AW-1:0]   pipe_addr_r, pipe_addr_nxt;
  logic [7:0]      pipe_mask_r, pipe_mask_nxt;

  // Result register
  pfb_pkg::out_t   out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Frame RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  pfb_pkg::seg_t   seg;
  pfb_pkg::chk_t   chk;

  logic            final_seg;
  logic [3:0]      chunk_n;
  logic [2:0]      lo_eff;
  logic [2:0]      hi_eff;
  logic [7:0]      mask;
  logic [7:0]      merged;
  logic            out_free;
  logic            out_load;
  logic            buf_clr;

  pfb_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfb_check #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_check (
    .seg (seg),
    .chk (chk)
  );

  // Geometry of the current segment: one line, or one rectangle edge
  always_comb begin
    seg.bad  = 1'b0;
    seg.vert = 1'b0;
    seg.col  = {1'b0, cmd_r.x};
    seg.row  = {2'b00, cmd_r.y};
    seg.len  = cmd_r.length;
    case (seg_r)
      pfb_pkg::EDGE_TOP: begin
        seg.vert = (cmd_r.mode == pfb_pkg::MODE_VLINE);
        seg.bad  = (cmd_r.mode != pfb_pkg::MODE_HLINE) &&
                   (cmd_r.mode != pfb_pkg::MODE_VLINE) &&
                   ((cmd_r.mode != pfb_pkg::MODE_RECT) ||
                    (cmd_r.length == 8'd0) || (cmd_r.height == 8'd0));
      end
      pfb_pkg::EDGE_BOTTOM: begin
        seg.row = {2'b00, cmd_r.y} + {2'b00, cmd_r.height} - 10'd1;
      end
      pfb_pkg::EDGE_LEFT: begin
        seg.vert = 1'b1;
        seg.len  = cmd_r.height;
      end
      pfb_pkg::EDGE_RIGHT: begin
        seg.vert = 1'b1;
        seg.col  = {1'b0, cmd_r.x} + {1'b0, cmd_r.length} - 9'd1;
        seg.len  = cmd_r.height;
      end
      default: begin
        seg.bad = 1'b1;
      end
    endcase
  end

  assign final_seg = (cmd_r.mode != pfb_pkg::MODE_RECT) || (seg_r == pfb_pkg::EDGE_RIGHT);

  // Chunk size and pixel mask
  always_comb begin
    if (vert_r) begin
      chunk_n = 4'd1;
    end else if (rem_r >= (CW+1)'(pfb_pkg::CHUNK_BYTES)) begin
      chunk_n = 4'(pfb_pkg::CHUNK_BYTES);
    end else begin
      chunk_n = 4'(rem_r);
    end
    lo_eff = first_r ? lo_r : 3'd0;
    hi_eff = (page_r == ep_r) ? hi_r : 3'd7;
    if (vert_r) begin
      mask = (8'hFF << lo_eff) & (8'hFF >> (3'd7 - hi_eff));
    end else begin
      mask = 8'h01 << lo_r;
    end
  end

  assign merged   = ram_rdata | pipe_mask_r;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == pfb_pkg::ST_OUT) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfb_pkg::ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = pfb_pkg::ST_IDLE;
        end
      end
      pfb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pfb_pkg::ST_SEG;
        end
      end
      pfb_pkg::ST_SEG: begin
        if (chk.status != pfb_pkg::STAT_OK || chk.empty) begin
          state_nxt = pfb_pkg::ST_OUT;
        end else begin
          state_nxt = pfb_pkg::ST_RUN;
        end
      end
      pfb_pkg::ST_RUN: begin
        if (iss_r + 4'd1 == chunk_n) begin
          state_nxt = pfb_pkg::ST_WAIT;
        end
      end
      pfb_pkg::ST_WAIT: begin
        state_nxt = pfb_pkg::ST_OUT;
      end
      pfb_pkg::ST_OUT: begin
        if (out_free) begin
          if (err_r || (final_seg && segdone_r)) begin
            state_nxt = pfb_pkg::ST_IDLE;
          end else if (segdone_r) begin
            state_nxt = pfb_pkg::ST_SEG;
          end else begin
            state_nxt = pfb_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = pfb_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs of the sequencer
  always_comb begin
    cmd_nxt       = cmd_r;
    seg_nxt       = seg_r;
    vert_nxt      = vert_r;
    page_nxt      = page_r;
    ep_nxt        = ep_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    first_nxt     = first_r;
    col_nxt       = col_r;
    ccol_nxt      = ccol_r;
    rem_nxt       = rem_r;
    iss_nxt       = iss_r;
    cnt_nxt       = cnt_r;
    segdone_nxt   = segdone_r;
    err_nxt       = err_r;
    stat_nxt      = stat_r;
    clr_nxt       = clr_r;
    buf_clr       = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = AW'(COLUMNS * int'(page_r) + int'(col_r));
    pipe_v_nxt    = 1'b0;
    pipe_k_nxt    = pipe_k_r;
    pipe_addr_nxt = pipe_addr_r;
    pipe_mask_nxt = pipe_mask_r;
    in_ready      = 1'b0;

    case (state_r)
      pfb_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
      end
      pfb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd_nxt  = in_data;
        seg_nxt  = pfb_pkg::EDGE_TOP;
      end
      pfb_pkg::ST_SEG: begin
        // Latch the segment walk; a failing or empty line ends the command
        err_nxt   = 1'b1;
        stat_nxt  = chk.status;
        vert_nxt  = seg.vert;
        page_nxt  = PW'(seg.row[9:3]);
        ep_nxt    = PW'(chk.end_row[9:3]);
        lo_nxt    = seg.row[2:0];
        hi_nxt    = chk.end_row[2:0];
        first_nxt = 1'b1;
        col_nxt   = CW'(seg.col);
        ccol_nxt  = CW'(seg.col);
        rem_nxt   = (CW+1)'(seg.len);
        iss_nxt   = 4'd0;
        buf_clr   = 1'b1;
        if (chk.status == pfb_pkg::STAT_OK && !chk.empty) begin
          err_nxt = 1'b0;
        end
      end
      pfb_pkg::ST_RUN: begin
        // Issue one frame RAM read a cycle for the current chunk
        ram_re        = 1'b1;
        pipe_v_nxt    = 1'b1;
        pipe_k_nxt    = iss_r[2:0];
        pipe_addr_nxt = ram_raddr;
        pipe_mask_nxt = mask;
        iss_nxt       = iss_r + 4'd1;
        if (!vert_r) begin
          col_nxt = col_r + CW'(1);
        end
        if (iss_r + 4'd1 == chunk_n) begin
          cnt_nxt = chunk_n;
          if (vert_r) begin
            segdone_nxt = (page_r == ep_r);
          end else begin
            segdone_nxt = (rem_r == (CW+1)'(chunk_n));
            rem_nxt     = rem_r - (CW+1)'(chunk_n);
          end
        end
      end
      pfb_pkg::ST_WAIT: begin
        // Last byte of the chunk is written back this cycle
      end
      pfb_pkg::ST_OUT: begin
        if (out_free) begin
          iss_nxt = 4'd0;
          buf_clr = 1'b1;
          if (segdone_r) begin
            seg_nxt = seg_r + 2'd1;
          end else if (vert_r) begin
            page_nxt  = page_r + PW'(1);
            first_nxt = 1'b0;
          end else begin
            ccol_nxt = col_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Frame RAM write port: clearing sweep or merged write-back
  always_comb begin
    if (state_r == pfb_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = pipe_v_r;
      ram_waddr = pipe_addr_r;
      ram_wdata = merged;
    end
  end

  // Collect merged bytes of the chunk
  always_comb begin
    buf_nxt = buf_r;
    if (buf_clr) begin
      buf_nxt = '0;
    end
    if (pipe_v_r) begin
      buf_nxt[{pipe_k_r, 3'b000} +: 8] = merged;
    end
  end

  // Result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (err_r) begin
        out_nxt.page        = 3'd0;
        out_nxt.column      = 7'd0;
        out_nxt.byte_count  = 4'd0;
        out_nxt.pixel_bytes = '0;
        out_nxt.status      = stat_r;
        out_nxt.last        = 1'b1;
      end else begin
        out_nxt.page        = 3'(page_r);
        out_nxt.column      = 7'(ccol_r);
        out_nxt.byte_count  = cnt_r;
        out_nxt.pixel_bytes = buf_r;
        out_nxt.status      = pfb_pkg::STAT_OK;
        out_nxt.last        = final_seg && segdone_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfb_pkg::ST_CLEAR;
      clr_r       <= '0;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    seg_r       <= seg_nxt;
    vert_r      <= vert_nxt;
    page_r      <= page_nxt;
    ep_r        <= ep_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    first_r     <= first_nxt;
    col_r       <= col_nxt;
    ccol_r      <= ccol_nxt;
    rem_r       <= rem_nxt;
    iss_r       <= iss_nxt;
    cnt_r       <= cnt_nxt;
    segdone_r   <= segdone_nxt;
    err_r       <= err_nxt;
    stat_r      <= stat_nxt;
    buf_r       <= buf_nxt;
    pipe_k_r    <= pipe_k_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    pipe_mask_r <= pipe_mask_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // A write-back only follows a read issued in the previous cycle
  a_pipe_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_v_r |-> (state_r == pfb_pkg::ST_RUN || state_r == pfb_pkg::ST_WAIT))
    else $error("write-back outside a chunk walk");

  // The final result of a command returns the sequencer to idle
  a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_nxt.last) |=> (state_r == pfb_pkg::ST_IDLE))
    else $error("command continued after its last result");

  // Data results carry status ok
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.byte_count != 4'd0) |-> (out_r.status == pfb_pkg::STAT_OK))
    else $error("data result with error status");

  // A status-only result always ends the command
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.byte_count == 4'd0) |-> out_r.last)
    else $error("status-only result not marked last");

  // No more than one chunk of bytes per result
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.byte_count <= 4'(pfb_pkg::CHUNK_BYTES)))
    else $error("byte count beyond chunk size");
`endif

endmodule
